### rtl/sbgg_pkg.sv
// Shared types, constants and helper functions for the slack-based gear governor.
// No dependencies; every other file imports this package.
`default_nettype none

package sbgg_pkg;

   localparam int WINDOW_DEPTH = 5;
   localparam int NUM_LEVELS   = 7;

   localparam int LEN_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int Q_W        = 24;
   localparam int SLACK_W    = 17;
   localparam int REL_W      = 18;
   localparam int GEAR_W     = 3;
   localparam int ACT_W      = 4;
   localparam int SKIP_W     = 8;
   localparam int CNT_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int WPTR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int NUM_W     = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W     = LEN_W + NUM_W;
   localparam int LHS_W     = SUM_W + FRAC_W;
   localparam int MUL_W     = Q_W + SUM_W;
   localparam int MUL_CNT_W = $clog2(Q_W + 1);
   localparam int DIVD_W    = LEN_W + FRAC_W;
   localparam int DIVR_W    = LEN_W;
   localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
   localparam int PDN_W     = 2 * Q_W;
   localparam int PUP_W     = REL_W + Q_W + 1;

   localparam logic [Q_W-1:0]     Q_ONE           = Q_W'(65536);
   localparam logic [Q_W-1:0]     Q_MAX           = {Q_W{1'b1}};
   localparam logic [Q_W-1:0]     JUMP_RATIO      = Q_W'(163840);
   localparam logic [Q_W-1:0]     LIMIT_STEP      = Q_W'(1311);
   localparam logic [Q_W-1:0]     DOWN_STEP       = Q_W'(16384);
   localparam logic [Q_W-1:0]     SLACK_LIMIT_RST = Q_W'(3277);
   localparam logic [Q_W-1:0]     ITER_THR_RST    = Q_W'(78643);
   localparam logic [Q_W-1:0]     BIAS_FACTOR_RST = Q_W'(65536);
   localparam logic [SKIP_W-1:0]  SKIP_RST        = SKIP_W'(1);
   localparam logic [SLACK_W-1:0] SLACK_ONE       = SLACK_W'(65536);
   localparam logic [GEAR_W-1:0]  LAST_LEVEL      = GEAR_W'(NUM_LEVELS - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLACK_LIMIT_INIT = 3'd0,
      CSR_ITER_THRESHOLD   = 3'd1,
      CSR_BIAS_FACTOR      = 3'd2,
      CSR_SKIP_COUNT       = 3'd3,
      CSR_SHIFT_ENABLE     = 3'd4
   } csr_idx_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_SKIPPED     = 4'd0,
      ACT_OBSERVED    = 4'd1,
      ACT_RESET       = 4'd2,
      ACT_RETURN      = 4'd3,
      ACT_NO_RETURN   = 4'd4,
      ACT_SLOWDOWN    = 4'd5,
      ACT_NO_SLOWDOWN = 4'd6,
      ACT_SPEEDUP     = 4'd7,
      ACT_NO_SPEEDUP  = 4'd8,
      ACT_NO_CHANGE   = 4'd9
   } action_type;

   typedef enum logic [1:0] {
      DIV_MOD,
      DIV_OWN,
      DIV_R1,
      DIV_R2
   } div_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_COUNT,
      ST_MOD,
      ST_MOD_W,
      ST_OWN,
      ST_OWN_W,
      ST_WIN,
      ST_R1,
      ST_R1_W,
      ST_R2,
      ST_R2_W,
      ST_SUM,
      ST_MUL,
      ST_MUL_W,
      ST_PROD,
      ST_DECIDE,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [Q_W-1:0]    iter_threshold;
      logic [Q_W-1:0]    bias_factor;
      logic [SKIP_W-1:0] skip_count;
      logic              shift_enable;
   } cfg_type;

   typedef struct packed {
      logic        take;
      logic        count;
      logic        div_start;
      div_sel_type div_sel;
      logic        own_cap;
      logic        win_write;
      logic        ratio_default;
      logic        ratio_cap;
      logic        ratio_max;
      logic        sum_cap;
      logic        mul_start;
      logic        prod_cap;
      logic        decide;
      logic        set_skip;
      logic        fin;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic skip_hit;
      logic observe_only;
      logic last_zero;
      logic second_zero;
   } sts_type;

   function automatic logic [Q_W-1:0] down_bias_rst(input int idx);
      logic [CNT_W-1:0] d;
      d = CNT_W'(Q_ONE) + CNT_W'(DOWN_STEP) * CNT_W'(idx);
      return (d > CNT_W'(Q_MAX)) ? Q_MAX : d[Q_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/sbgg_if.sv
// Handshake channel interfaces: request, response and register write.
// Depends on sbgg_pkg for field widths.
`default_nettype none

interface sbgg_req_if import sbgg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEN_W-1:0]   iter_length_us;
   logic [LEN_W-1:0]   wait_time_us;
   logic [SLACK_W-1:0] min_slack;
   modport source (output valid, iter_length_us, wait_time_us, min_slack, input ready);
   modport sink (input valid, iter_length_us, wait_time_us, min_slack, output ready);
endinterface

interface sbgg_rsp_if import sbgg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [GEAR_W-1:0]        gear;
   logic [ACT_W-1:0]         action;
   logic signed [REL_W-1:0]  relative_slack;
   modport source (output valid, gear, action, relative_slack, input ready);
   modport sink (input valid, gear, action, relative_slack, output ready);
endinterface

interface sbgg_csr_if import sbgg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/sbgg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sbgg_pkg.
`default_nettype none

module sbgg_div import sbgg_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [DIVR_W-1:0] divisor,
   output logic                   done,
   output logic [DIVD_W-1:0]      quotient,
   output logic [DIVR_W-1:0]      remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [DIVR_W-1:0]    dvs_ff, dvs_in;
   logic [DIVR_W:0]      rem_sh;
   logic [DIVR_W:0]      diff;
   logic                 ge;

   assign rem_sh = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/sbgg_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on sbgg_pkg.
`default_nettype none

module sbgg_mul import sbgg_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] mcand,
   input  wire logic [Q_W-1:0]   mplier,
   output logic                  done,
   output logic [MUL_W-1:0]      product
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_W-1:0]     acc_ff, acc_in;
   logic [MUL_W-1:0]     mc_ff, mc_in;
   logic [Q_W-1:0]       mp_ff, mp_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MUL_CNT_W'(Q_W);
         acc_in  = '0;
         mc_in   = MUL_W'(mcand);
         mp_in   = mplier;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in  = {mc_ff[MUL_W-2:0], 1'b0};
         mp_in  = {1'b0, mp_ff[Q_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

### rtl/sbgg_dp.sv
// Datapath: governor state, length window, bias tables and gear decision.
// Depends on sbgg_pkg, sbgg_div and sbgg_mul.
`default_nettype none

module sbgg_dp import sbgg_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic [LEN_W-1:0]   in_length,
   input  wire logic [LEN_W-1:0]   in_wait,
   input  wire logic [SLACK_W-1:0] in_gmin,
   output logic [GEAR_W-1:0]       out_gear,
   output logic [ACT_W-1:0]        out_action,
   output logic signed [REL_W-1:0] out_rel
);

   logic [LEN_W-1:0]   len_ff, wait_ff;
   logic [SLACK_W-1:0] gmin_ff;
   logic [CNT_W-1:0]   mc_ff, mc_in;
   logic [GEAR_W-1:0]  level_ff, level_in;
   logic [Q_W-1:0]     down_ff [NUM_LEVELS];
   logic [Q_W-1:0]     down_in [NUM_LEVELS];
   logic [Q_W-1:0]     up_ff [NUM_LEVELS];
   logic [Q_W-1:0]     up_in [NUM_LEVELS];
   logic               raised_ff, raised_in;
   logic               lowered_ff, lowered_in;
   logic [LEN_W-1:0]   last_ff, second_ff;
   logic [LEN_W-1:0]   win_ff [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] wvalid_ff;
   logic [WPTR_W-1:0]  wptr_ff;
   logic [Q_W-1:0]     slimit_ff, slimit_in;
   logic [SLACK_W-1:0] own_ff;
   logic [Q_W-1:0]     ratio_ff;
   logic [SUM_W-1:0]   sum_ff, sum_c;
   logic [NUM_W-1:0]   num_ff, num_c;
   logic [LHS_W-1:0]   lhs_ff;
   logic [PDN_W-1:0]   pdown_ff;
   logic signed [PUP_W-1:0] pup_ff;
   action_type         act_ff, act_in;
   logic signed [REL_W-1:0] relout_ff, relout_in;
   logic [GEAR_W-1:0]  gear_out_ff;
   logic [ACT_W-1:0]   act_out_ff;
   logic signed [REL_W-1:0] rel_out_ff;

   logic [SKIP_W-1:0]  skip_eff;
   logic [DIVD_W-1:0]  div_dividend, div_quo;
   logic [DIVR_W-1:0]  div_divisor, div_rem;
   logic               div_done, mul_done;
   logic [MUL_W-1:0]   mul_prod;
   logic [Q_W-1:0]     quo_sat;
   logic [SLACK_W-1:0] own_sat;
   logic signed [REL_W-1:0] rel;
   logic               jump_c, ret_c, down_c, up_c, use_down;
   logic signed [PDN_W+1:0] rel_sh, pdown_s;
   logic signed [PUP_W+1:0] pup4, slim_sh;
   logic [Q_W-1:0]     scale_src, scaled;
   logic [PDN_W-1:0]   scale_prod;
   logic [Q_W:0]       slimit_sum;

   assign skip_eff = (cfg.skip_count == '0) ? SKIP_W'(1) : cfg.skip_count;

   always_comb begin
      case (cmd.div_sel)
         DIV_MOD: begin
            div_dividend = DIVD_W'(mc_ff);
            div_divisor  = DIVR_W'(skip_eff);
         end
         DIV_OWN: begin
            div_dividend = {wait_ff, FRAC_W'(0)};
            div_divisor  = len_ff;
         end
         DIV_R1: begin
            div_dividend = {len_ff, FRAC_W'(0)};
            div_divisor  = last_ff;
         end
         default: begin
            div_dividend = {len_ff, FRAC_W'(0)};
            div_divisor  = second_ff;
         end
      endcase
   end

   sbgg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   sbgg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .mcand   (sum_ff),
      .mplier  (cfg.iter_threshold),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign quo_sat = (div_quo > DIVD_W'(Q_MAX)) ? Q_MAX : div_quo[Q_W-1:0];
   assign own_sat = (div_quo > DIVD_W'(SLACK_ONE)) ? SLACK_ONE : div_quo[SLACK_W-1:0];
   assign rel     = $signed({1'b0, own_ff}) - $signed({1'b0, gmin_ff});

   always_comb begin
      sum_c = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (wvalid_ff[i]) begin
            sum_c = sum_c + SUM_W'(win_ff[i]);
         end
      end
      num_c = NUM_W'($countones(wvalid_ff));
   end

   // Threshold compares, all on registered products
   assign jump_c   = (ratio_ff >= JUMP_RATIO);
   assign ret_c    = (MUL_W'(lhs_ff) > mul_prod) && lowered_ff;
   assign rel_sh   = {{(PDN_W+2-REL_W-FRAC_W){rel[REL_W-1]}}, rel, FRAC_W'(0)};
   assign pdown_s  = $signed({2'b00, pdown_ff});
   assign down_c   = (rel_sh > pdown_s);
   assign pup4     = {pup_ff, 2'b00};
   assign slim_sh  = $signed({(PUP_W+2-Q_W-FRAC_W)'(0), slimit_ff, FRAC_W'(0)});
   assign up_c     = (pup4 < slim_sh);
   assign use_down = !jump_c && !ret_c && !raised_ff && down_c;

   assign scale_src  = use_down ? down_ff[level_ff] : up_ff[level_ff];
   assign scale_prod = scale_src * cfg.bias_factor;
   assign scaled     = (scale_prod[PDN_W-1:FRAC_W] > (PDN_W-FRAC_W)'(Q_MAX)) ? Q_MAX
                       : scale_prod[FRAC_W+Q_W-1:FRAC_W];
   assign slimit_sum = {1'b0, slimit_ff} + {1'b0, LIMIT_STEP};

   assign mc_in = cmd.count ? (mc_ff + 1'b1) : mc_ff;

   always_comb begin
      level_in   = level_ff;
      raised_in  = raised_ff;
      lowered_in = lowered_ff;
      slimit_in  = slimit_ff;
      act_in     = act_ff;
      relout_in  = relout_ff;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         down_in[i] = down_ff[i];
         up_in[i]   = up_ff[i];
      end
      if (cmd.count && (mc_in == CNT_W'(1))) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            down_in[i] = down_bias_rst(i);
            up_in[i]   = Q_ONE;
         end
      end
      if (cmd.set_skip) begin
         act_in    = ACT_SKIPPED;
         relout_in = '0;
      end
      if (cmd.win_write) begin
         act_in    = ACT_OBSERVED;
         relout_in = (mc_ff == CNT_W'(1)) ? '0 : rel;
      end
      if (cmd.decide) begin
         if (jump_c) begin
            level_in = '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
               down_in[i] = down_bias_rst(i);
               up_in[i]   = Q_ONE;
            end
            act_in = ACT_RESET;
         end else if (ret_c) begin
            if (level_ff != '0) begin
               level_in          = level_ff - 1'b1;
               up_in[level_ff]   = scaled;
               raised_in         = 1'b1;
               lowered_in        = 1'b0;
               slimit_in         = slimit_sum[Q_W] ? Q_MAX : slimit_sum[Q_W-1:0];
               act_in            = ACT_RETURN;
            end else begin
               raised_in  = 1'b0;
               lowered_in = 1'b0;
               act_in     = ACT_NO_RETURN;
            end
         end else if (!raised_ff && down_c) begin
            if (level_ff != LAST_LEVEL) begin
               down_in[level_ff] = scaled;
               level_in          = level_ff + 1'b1;
               raised_in         = 1'b0;
               lowered_in        = 1'b1;
               act_in            = ACT_SLOWDOWN;
            end else begin
               raised_in  = 1'b0;
               lowered_in = 1'b0;
               act_in     = ACT_NO_SLOWDOWN;
            end
         end else if (!lowered_ff && up_c) begin
            if (level_ff != '0) begin
               level_in        = level_ff - 1'b1;
               up_in[level_ff] = scaled;
               raised_in       = 1'b1;
               lowered_in      = 1'b0;
               act_in          = ACT_SPEEDUP;
            end else begin
               raised_in  = 1'b0;
               lowered_in = 1'b0;
               act_in     = ACT_NO_SPEEDUP;
            end
         end else begin
            raised_in  = 1'b0;
            lowered_in = 1'b0;
            act_in     = ACT_NO_CHANGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mc_ff      <= '0;
         level_ff   <= '0;
         raised_ff  <= 1'b0;
         lowered_ff <= 1'b0;
         last_ff    <= '0;
         second_ff  <= '0;
         wvalid_ff  <= '0;
         wptr_ff    <= '0;
         slimit_ff  <= SLACK_LIMIT_RST;
         act_ff     <= ACT_SKIPPED;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            down_ff[i] <= down_bias_rst(i);
            up_ff[i]   <= Q_ONE;
         end
      end else begin
         mc_ff      <= mc_in;
         level_ff   <= level_in;
         raised_ff  <= raised_in;
         lowered_ff <= lowered_in;
         slimit_ff  <= slimit_in;
         act_ff     <= act_in;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            down_ff[i] <= down_in[i];
            up_ff[i]   <= up_in[i];
         end
         if (cmd.win_write) begin
            wvalid_ff[wptr_ff] <= 1'b1;
            wptr_ff <= (wptr_ff == WPTR_W'(WINDOW_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (cmd.fin) begin
            second_ff <= last_ff;
            last_ff   <= len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      relout_ff <= relout_in;
      if (cmd.take) begin
         len_ff  <= in_length;
         wait_ff <= in_wait;
         gmin_ff <= (in_gmin > SLACK_ONE) ? SLACK_ONE : in_gmin;
      end
      if (cmd.win_write) begin
         win_ff[wptr_ff] <= len_ff;
      end
      if (cmd.own_cap) begin
         own_ff <= own_sat;
      end
      if (cmd.ratio_default) begin
         ratio_ff <= cfg.iter_threshold;
      end else if (cmd.ratio_cap) begin
         if (!cmd.ratio_max || (quo_sat > ratio_ff)) begin
            ratio_ff <= quo_sat;
         end
      end
      if (cmd.sum_cap) begin
         if (mc_ff < CNT_W'(WINDOW_DEPTH)) begin
            sum_ff <= SUM_W'(last_ff);
            num_ff <= NUM_W'(1);
         end else begin
            sum_ff <= sum_c;
            num_ff <= num_c;
         end
      end
      if (cmd.prod_cap) begin
         lhs_ff   <= {SUM_W'(len_ff) * SUM_W'(num_ff), FRAC_W'(0)};
         pdown_ff <= slimit_ff * down_ff[level_ff];
         pup_ff   <= rel * $signed({1'b0, up_ff[level_ff]});
      end
      if (cmd.out_load) begin
         gear_out_ff <= level_ff;
         act_out_ff  <= act_ff;
         rel_out_ff  <= relout_ff;
      end
   end

   assign sts.div_done     = div_done;
   assign sts.mul_done     = mul_done;
   assign sts.skip_hit     = (div_rem != '0);
   assign sts.observe_only = (mc_ff == CNT_W'(1)) || !cfg.shift_enable;
   assign sts.last_zero    = (last_ff == '0);
   assign sts.second_zero  = (second_ff == '0);

   assign out_gear   = gear_out_ff;
   assign out_action = act_out_ff;
   assign out_rel    = rel_out_ff;

endmodule

`default_nettype wire

### rtl/sbgg_ctrl.sv
// Controller state machine: sequences the datapath and owns the channel handshakes.
// Depends on sbgg_pkg.
`default_nettype none

module sbgg_ctrl import sbgg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_ok;

   assign out_ok = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_COUNT;
         ST_COUNT:  state_in = ST_MOD;
         ST_MOD:    state_in = ST_MOD_W;
         ST_MOD_W: begin
            if (sts.div_done) state_in = sts.skip_hit ? ST_OUT : ST_OWN;
         end
         ST_OWN:    state_in = ST_OWN_W;
         ST_OWN_W:  if (sts.div_done) state_in = ST_WIN;
         ST_WIN:    state_in = sts.observe_only ? ST_FIN : ST_R1;
         ST_R1:     state_in = sts.last_zero ? ST_SUM : ST_R1_W;
         ST_R1_W: begin
            if (sts.div_done) state_in = sts.second_zero ? ST_SUM : ST_R2;
         end
         ST_R2:     state_in = ST_R2_W;
         ST_R2_W:   if (sts.div_done) state_in = ST_SUM;
         ST_SUM:    state_in = ST_MUL;
         ST_MUL:    state_in = ST_MUL_W;
         ST_MUL_W:  if (sts.mul_done) state_in = ST_PROD;
         ST_PROD:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_FIN;
         ST_FIN:    state_in = ST_OUT;
         ST_OUT:    if (out_ok) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = DIV_MOD;
      unique case (state_ff)
         ST_IDLE:   cmd.take = req_valid;
         ST_COUNT:  cmd.count = 1'b1;
         ST_MOD:    cmd.div_start = 1'b1;
         ST_MOD_W:  cmd.set_skip = sts.div_done && sts.skip_hit;
         ST_OWN: begin
            cmd.div_sel   = DIV_OWN;
            cmd.div_start = 1'b1;
         end
         ST_OWN_W:  cmd.own_cap = sts.div_done;
         ST_WIN:    cmd.win_write = 1'b1;
         ST_R1: begin
            cmd.div_sel       = DIV_R1;
            cmd.div_start     = !sts.last_zero;
            cmd.ratio_default = sts.last_zero;
         end
         ST_R1_W:   cmd.ratio_cap = sts.div_done;
         ST_R2: begin
            cmd.div_sel   = DIV_R2;
            cmd.div_start = 1'b1;
         end
         ST_R2_W: begin
            cmd.ratio_cap = sts.div_done;
            cmd.ratio_max = 1'b1;
         end
         ST_SUM:    cmd.sum_cap = 1'b1;
         ST_MUL:    cmd.mul_start = 1'b1;
         ST_MUL_W:  cmd.div_sel = DIV_MOD;
         ST_PROD:   cmd.prod_cap = 1'b1;
         ST_DECIDE: cmd.decide = 1'b1;
         ST_FIN:    cmd.fin = 1'b1;
         ST_OUT:    cmd.out_load = out_ok;
         default:   cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/slack_based_gear_governor.sv
// Slack-based gear governor top level: register file, controller and datapath.
// Depends on sbgg_pkg, sbgg_if, sbgg_ctrl and sbgg_dp.
//
//   channel   dir  payload                                  handshake
//   req_bus   in   iter_length_us, wait_time_us, min_slack  valid/ready
//   rsp_bus   out  gear, action, relative_slack             valid/ready
//   csr_bus   in   index, data                              valid/ready (always ready)
//
// One request at a time. A skipped marker is decided by the skip remainder on the
// serial divider alone; an evaluated marker runs up to four 48-step divisions
// and a 24-step multiply.
// Synchronous active-high reset; bias tables and window valid bits clear at once.
// A finished response waits in an output register while the next request is
// taken; a stalled rsp_bus holds only the next result until the hand-off.
`default_nettype none

module slack_based_gear_governor import sbgg_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   sbgg_req_if.sink   req_bus,
   sbgg_rsp_if.source rsp_bus,
   sbgg_csr_if.sink   csr_bus
);

   logic [Q_W-1:0]    iter_threshold_ff;
   logic [Q_W-1:0]    bias_factor_ff;
   logic [SKIP_W-1:0] skip_count_ff;
   logic              shift_enable_ff;
   cfg_type           cfg;
   cmd_type           cmd;
   sts_type           sts;

   // slack_limit_init only matters at reset, where its reset value applies
   always_ff @(posedge clock) begin
      if (reset) begin
         iter_threshold_ff <= ITER_THR_RST;
         bias_factor_ff    <= BIAS_FACTOR_RST;
         skip_count_ff     <= SKIP_RST;
         shift_enable_ff   <= 1'b1;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ITER_THRESHOLD: iter_threshold_ff <= csr_bus.data;
            CSR_BIAS_FACTOR:    bias_factor_ff    <= csr_bus.data;
            CSR_SKIP_COUNT:     skip_count_ff     <= csr_bus.data[SKIP_W-1:0];
            CSR_SHIFT_ENABLE:   shift_enable_ff   <= csr_bus.data[0];
            default:            shift_enable_ff   <= shift_enable_ff;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   assign cfg.iter_threshold = iter_threshold_ff;
   assign cfg.bias_factor    = bias_factor_ff;
   assign cfg.skip_count     = skip_count_ff;
   assign cfg.shift_enable   = shift_enable_ff;

   sbgg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sbgg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .sts        (sts),
      .in_length  (req_bus.iter_length_us),
      .in_wait    (req_bus.wait_time_us),
      .in_gmin    (req_bus.min_slack),
      .out_gear   (rsp_bus.gear),
      .out_action (rsp_bus.action),
      .out_rel    (rsp_bus.relative_slack)
   );

endmodule

`default_nettype wire

### rtl/sbgg_checker.sv
// Port-level checks for the gear governor, bound to the top level.
// Depends on sbgg_pkg and slack_based_gear_governor.
`default_nettype none

module sbgg_checker import sbgg_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [GEAR_W-1:0]       gear,
   input wire logic [ACT_W-1:0]        action,
   input wire logic signed [REL_W-1:0] relative_slack
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(gear) && $stable(action)
                                  && $stable(relative_slack))
      else $error("response changed while stalled");

   a_gear_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> gear <= LAST_LEVEL)
      else $error("gear out of range");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && action == ACT_SKIPPED |-> relative_slack == '0)
      else $error("skipped marker reports slack");

   a_reset_gear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && action == ACT_RESET |-> gear == '0)
      else $error("gear reset did not give gear zero");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

endmodule

bind slack_based_gear_governor sbgg_checker u_sbgg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .gear           (rsp_bus.gear),
   .action         (rsp_bus.action),
   .relative_slack (rsp_bus.relative_slack)
);

`default_nettype wire

### test/gear_checker.sv
// Checker for the slack-based gear governor: tracks register writes, predicts the
// response of every accepted request and compares it with what the block returns.
// Depends on sbgg_pkg and the channel interfaces in sbgg_if.
`timescale 1ns / 1ps

module gear_checker import sbgg_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   sbgg_req_if      req,
   sbgg_rsp_if      rsp,
   sbgg_csr_if      csr,
   output int       errors,
   output int       pending
);

   typedef struct packed {
      logic [GEAR_W-1:0]       gear;
      action_type              action;
      logic signed [REL_W-1:0] rel;
   } gear_resp_type;

   gear_resp_type resp_q[$];

   logic [Q_W-1:0]    thr_cfg, factor_cfg;
   logic [SKIP_W-1:0] skip_cfg;
   logic              shift_cfg;

   int unsigned    level;
   longint         dn_bias[NUM_LEVELS];
   longint         up_bias[NUM_LEVELS];
   bit             raised, lowered;
   longint         last_len, prev_len;
   longint         win[WINDOW_DEPTH];
   bit [WINDOW_DEPTH-1:0] win_ok;
   int             wptr;
   logic [CNT_W-1:0] markers;
   longint         limit;

   function automatic longint scale_bias(longint b);
      longint p;
      p = (b * longint'(factor_cfg)) >>> 16;
      return (p > longint'(Q_MAX)) ? longint'(Q_MAX) : p;
   endfunction

   function automatic longint q_ratio(longint a, longint b);
      longint r;
      r = (a <<< 16) / b;
      return (r > longint'(Q_MAX)) ? longint'(Q_MAX) : r;
   endfunction

   task automatic clear_biases();
      for (int i = 0; i < NUM_LEVELS; i++) begin
         up_bias[i] = 65536;
         dn_bias[i] = 65536 + 16384 * i;
      end
   endtask

   task automatic predict_gear(input longint len, input longint wt, input longint gm,
                               output gear_resp_type r);
      int unsigned skip, g;
      longint own, rel, ratio, r2, sum, num;
      action_type act;
      markers = markers + 1;
      if (markers == 1) clear_biases();
      skip = (skip_cfg == 0) ? 1 : skip_cfg;
      if (markers % skip != 0) begin
         r.gear = level[GEAR_W-1:0];
         r.action = ACT_SKIPPED;
         r.rel = '0;
         return;
      end
      if (len == 0) own = 65536;
      else begin
         own = (wt <<< 16) / len;
         if (own > 65536) own = 65536;
      end
      if (gm > 65536) gm = 65536;
      win[wptr] = len;
      win_ok[wptr] = 1'b1;
      wptr = (wptr + 1) % WINDOW_DEPTH;
      act = ACT_OBSERVED;
      rel = 0;
      if (markers != 1) begin
         rel = own - gm;
         if (shift_cfg) begin
            g = level;
            if (last_len == 0) ratio = thr_cfg;
            else begin
               ratio = q_ratio(len, last_len);
               if (prev_len != 0) begin
                  r2 = q_ratio(len, prev_len);
                  if (r2 > ratio) ratio = r2;
               end
            end
            sum = 0;
            num = 0;
            if (markers < 5) begin
               sum = last_len;
               num = 1;
            end else begin
               for (int i = 0; i < WINDOW_DEPTH; i++)
                  if (win_ok[i]) begin
                     sum += win[i];
                     num++;
                  end
            end
            if (g >= NUM_LEVELS) g = NUM_LEVELS - 1;
            if (ratio >= 163840) begin
               level = 0;
               clear_biases();
               act = ACT_RESET;
            end else if ((len <<< 16) * num > longint'(thr_cfg) * sum && lowered) begin
               if (g != 0) begin
                  level = g - 1;
                  up_bias[g] = scale_bias(up_bias[g]);
                  raised = 1;
                  lowered = 0;
                  limit += 1311;
                  if (limit > longint'(Q_MAX)) limit = Q_MAX;
                  act = ACT_RETURN;
               end else begin
                  raised = 0;
                  lowered = 0;
                  act = ACT_NO_RETURN;
               end
            end else if (!raised && rel * 65536 > limit * dn_bias[g]) begin
               if (g != NUM_LEVELS - 1) begin
                  dn_bias[g] = scale_bias(dn_bias[g]);
                  level = g + 1;
                  raised = 0;
                  lowered = 1;
                  act = ACT_SLOWDOWN;
               end else begin
                  raised = 0;
                  lowered = 0;
                  act = ACT_NO_SLOWDOWN;
               end
            end else if (!lowered && rel * 4 * up_bias[g] < limit * 65536) begin
               if (g != 0) begin
                  level = g - 1;
                  up_bias[g] = scale_bias(up_bias[g]);
                  raised = 1;
                  lowered = 0;
                  act = ACT_SPEEDUP;
               end else begin
                  raised = 0;
                  lowered = 0;
                  act = ACT_NO_SPEEDUP;
               end
            end else begin
               raised = 0;
               lowered = 0;
               act = ACT_NO_CHANGE;
            end
         end
      end
      prev_len = last_len;
      last_len = len;
      r.gear = level[GEAR_W-1:0];
      r.action = act;
      r.rel = rel[REL_W-1:0];
   endtask

   always @(posedge clock) begin
      gear_resp_type want, got;
      if (reset) begin
         thr_cfg = ITER_THR_RST;
         factor_cfg = BIAS_FACTOR_RST;
         skip_cfg = SKIP_RST;
         shift_cfg = 1'b1;
         level = 0;
         clear_biases();
         raised = 0;
         lowered = 0;
         last_len = 0;
         prev_len = 0;
         for (int i = 0; i < WINDOW_DEPTH; i++) win[i] = 0;
         win_ok = '0;
         wptr = 0;
         markers = '0;
         limit = SLACK_LIMIT_RST;
         resp_q.delete();
         errors = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr_idx_type'(csr.index))
               CSR_ITER_THRESHOLD: thr_cfg = csr.data;
               CSR_BIAS_FACTOR:    factor_cfg = csr.data;
               CSR_SKIP_COUNT:     skip_cfg = csr.data[SKIP_W-1:0];
               CSR_SHIFT_ENABLE:   shift_cfg = csr.data[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            predict_gear(longint'(req.iter_length_us), longint'(req.wait_time_us),
                         longint'(req.min_slack), want);
            resp_q.push_back(want);
         end
         if (rsp.valid && rsp.ready) begin
            got.gear = rsp.gear;
            got.action = action_type'(rsp.action);
            got.rel = rsp.relative_slack;
            if (resp_q.size() == 0) begin
               $display("%0t: unexpected response gear %0d action %0d rel %0d",
                        $time, got.gear, got.action, got.rel);
               errors++;
            end else begin
               want = resp_q.pop_front();
               if (got.gear !== want.gear) begin
                  $display("%0t: gear expected %0d actual %0d", $time, want.gear, got.gear);
                  errors++;
               end
               if (got.action !== want.action) begin
                  $display("%0t: action expected %0d actual %0d",
                           $time, want.action, got.action);
                  errors++;
               end
               if (got.rel !== want.rel) begin
                  $display("%0t: relative_slack expected %0d actual %0d",
                           $time, want.rel, got.rel);
                  errors++;
               end
            end
         end
      end
      pending = resp_q.size();
   end

endmodule

### test/tb.sv
// Top of the gear governor testbench: clock, reset, register phases, request
// stimulus with idling and back-pressure, and the verdict.
// Depends on sbgg_pkg, sbgg_if, the block and gear_checker.
`timescale 1ns / 1ps

module tb;
   import sbgg_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors, pending;
   int   idle_pct = 0, stall_pct = 0;
   logic long_hold = 1'b0;
   bit   hold_done = 0;
   int   hold_left = 0;
   longint cycles = 0;
   longint base_len = 10000;

   sbgg_req_if req_bus();
   sbgg_rsp_if rsp_bus();
   sbgg_csr_if csr_bus();

   slack_based_gear_governor dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   gear_checker chk (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus), .csr(csr_bus),
      .errors(errors), .pending(pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.iter_length_us = '0;
      req_bus.wait_time_us = '0;
      req_bus.min_slack = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 4000000) begin
         $display("slack_based_gear_governor verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (long_hold && !hold_done) begin
         hold_done = 1;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_marker(logic [31:0] len, logic [31:0] wt, logic [16:0] gm);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.iter_length_us <= len;
      req_bus.wait_time_us <= wt;
      req_bus.min_slack <= gm;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_markers(int count);
      longint len, wt;
      int unsigned pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_marker($urandom_range(32'hFFFFFFFF, 1), $urandom,
                        17'($urandom_range(65536)));
         end else begin
            if (pick < 14) base_len = longint'($urandom_range(2000000, 100));
            len = base_len + longint'($urandom_range(32'(base_len / 8)));
            if (pick >= 14 && pick < 18) len = base_len * 3;
            else if (pick >= 18 && pick < 30) len = (base_len * 3) / 2;
            wt = (len * longint'($urandom_range(14000))) >>> 16;
            send_marker(len[31:0], wt[31:0], 17'($urandom_range(5000)));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_marker(32'd1, 32'd0, 17'd0);
      send_marker(32'hFFFFFFFF, 32'hFFFFFFFF, 17'd65536);
      send_marker(32'd1, 32'hFFFFFFFF, 17'd0);
      send_marker(32'd1000, 32'd2000, 17'd65536);
      send_marker(32'd1000, 32'd0, 17'd0);
      send_marker(32'd1000, 32'd900, 17'd0);
      send_marker(32'd1000, 32'd900, 17'd100);
      send_marker(32'd1000, 32'd10, 17'd0);
      send_marker(32'd1600, 32'd10, 17'd0);
      send_marker(32'd1000, 32'd800, 17'd0);
      send_marker(32'd1500, 32'd800, 17'd0);
      send_marker(32'd5000, 32'd0, 17'd0);
      send_marker(32'd5000, 32'd4000, 17'd1000);
      send_marker(32'hFFFFFFFF, 32'd0, 17'd65536);
      send_marker(32'h80000000, 32'h7FFFFFFF, 17'd32768);
      wait_idle();

      write_reg(CSR_SLACK_LIMIT_INIT, 24'hFFFFFF);
      write_reg(CSR_ITER_THRESHOLD, 24'd0);
      write_reg(CSR_BIAS_FACTOR, 24'd0);
      write_reg(CSR_SKIP_COUNT, 24'd1);
      write_reg(CSR_SHIFT_ENABLE, 24'd1);
      random_markers(150);
      wait_idle();

      idle_pct = 49;
      write_reg(CSR_SLACK_LIMIT_INIT, 24'd0);
      write_reg(CSR_ITER_THRESHOLD, 24'hFFFFFF);
      write_reg(CSR_BIAS_FACTOR, 24'hFFFFFF);
      write_reg(CSR_SHIFT_ENABLE, 24'd0);
      random_markers(100);
      wait_idle();

      idle_pct = 0;
      stall_pct = 49;
      write_reg(CSR_SHIFT_ENABLE, 24'd1);
      write_reg(CSR_ITER_THRESHOLD, 24'd78643);
      write_reg(CSR_BIAS_FACTOR, 24'd60000);
      write_reg(CSR_SKIP_COUNT, 24'd3);
      random_markers(200);
      wait_idle();

      idle_pct = 26;
      stall_pct = 26;
      write_reg(CSR_SKIP_COUNT, 24'd255);
      random_markers(60);
      wait_idle();

      idle_pct = 0;
      stall_pct = 0;
      write_reg(CSR_SKIP_COUNT, 24'd1);
      write_reg(CSR_BIAS_FACTOR, 24'd80000);
      long_hold <= 1'b1;
      random_markers(200);
      wait_idle();

      idle_pct = 49;
      stall_pct = 49;
      write_reg(CSR_BIAS_FACTOR, 24'd65536);
      write_reg(CSR_SKIP_COUNT, 24'd2);
      random_markers(150);
      wait_idle();

      idle_pct = 26;
      stall_pct = 26;
      write_reg(CSR_SKIP_COUNT, 24'd1);
      write_reg(CSR_ITER_THRESHOLD, 24'd70000);
      random_markers(275);
      wait_idle();

      repeat (300) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("slack_based_gear_governor verification clean");
      end else begin
         $display("slack_based_gear_governor verification failed");
      end
      $finish;
   end

endmodule
